>>> design/clfsc_pkg.sv
package clfsc_pkg;

    localparam int WORD_W     = 32;
    localparam int RING_DEPTH = 64;
    localparam int HEAD_W     = $clog2(RING_DEPTH);
    localparam int NUM_GEN    = 3;

    localparam logic [HEAD_W-1:0] HEAD_RESET = HEAD_W'(RING_DEPTH - 1);

    localparam logic [WORD_W-1:0] SEED_MASK = 32'h0502_7919;
    localparam logic [WORD_W-1:0] PAIR_LO   = 32'h5555_5555;
    localparam logic [WORD_W-1:0] PAIR_HI   = 32'hAAAA_AAAA;
    localparam logic [WORD_W-1:0] NIB_LO    = 32'h0F0F_0F0F;
    localparam logic [WORD_W-1:0] NIB_HI    = 32'hF0F0_F0F0;

    // Lags per generator, generator one in the lowest slot
    localparam logic [NUM_GEN-1:0][HEAD_W-1:0] LAG_A = {6'd58, 6'd57, 6'd55};
    localparam logic [NUM_GEN-1:0][HEAD_W-1:0] LAG_B = {6'd19, 6'd7, 6'd24};

    localparam logic MODE_RESEED = 1'b0;
    localparam logic MODE_DATA   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_COMBINE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic start_fill;
        logic fill_step;
        logic combine;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic phase_zero;
        logic fill_done;
        logic out_free;
    } status_t;

    // One right shift; taps 31, 6, 4, 2, 1, 0 feed the new bit 31
    function automatic logic [WORD_W-1:0] lfsr_next(input logic [WORD_W-1:0] v);
        logic fb;
        fb = v[31] ^ v[6] ^ v[4] ^ v[2] ^ v[1] ^ v[0];
        return {fb, v[WORD_W-1:1]};
    endfunction

endpackage

>>> design/clocked_lagged_fib_stream_cipher_top.sv
// Clock-controlled lagged Fibonacci stream cipher. Each slave item is either
// a reseed (tuser = 0, seed in tdata[31:0]) or a data byte (tuser = 1, byte in
// tdata[39:32], tlast marking the end of the caller's buffer). A data byte
// leaves on the master side XORed with the next keystream byte, tlast carried
// along; a reseed gives no result. Keystream words come from three 64-word
// rings stepped by a carry-majority rule and are spent least significant byte
// first; the position carries across buffers and only a reseed restarts it.
// Before the first reseed the keystream is zero and data passes unchanged.
// Order: a data byte that opens a new keystream word first passes a word
// update (ring read, add and write-back through the ring RAMs' registered
// read) before it is emitted. A reseed holds off the next item while the three
// seed LFSRs advance one step a cycle and store one ring word every
// LFSR_STEPS_PER_WORD steps. The result sits in an output register, so the
// next item is taken while a result waits.
module clocked_lagged_fib_stream_cipher_top #(
    parameter int LFSR_STEPS_PER_WORD = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] seed, [39:32] data_in
    input  logic        s_tuser,   // [0] mode
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] data_out
    output logic        m_tlast
);

    import clfsc_pkg::*;

    cmd_t    cmd;
    status_t sts;

    // Sequence the item: accept, ring fill or word update, then hand over
    clfsc_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_tvalid),
        .mode    (s_tuser),
        .s_ready (s_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Hold the rings, generator state and output register
    clfsc_dp #(
        .LFSR_STEPS_PER_WORD (LFSR_STEPS_PER_WORD)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .seed      (s_tdata[31:0]),
        .data_in   (s_tdata[39:32]),
        .last_in   (s_tlast),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .data_out  (m_tdata),
        .last_out  (m_tlast)
    );

endmodule

>>> design/clfsc_ram.sv
module clfsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

>>> design/clfsc_ctrl.sv
module clfsc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_valid,
    input  logic               mode,
    output logic               s_ready,
    input  clfsc_pkg::status_t sts,
    output clfsc_pkg::cmd_t    cmd
);

    import clfsc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_ready = 1'b1;
                if (s_valid)
                begin
                    cmd.load = 1'b1;
                    if (mode == MODE_RESEED)
                    begin
                        cmd.start_fill = 1'b1;
                        state_next     = ST_FILL;
                    end
                    else if (sts.phase_zero)
                    begin
                        state_next = ST_COMBINE;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_FILL:
            begin
                cmd.fill_step = 1'b1;
                if (sts.fill_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_COMBINE:
            begin
                cmd.combine = 1'b1;
                state_next  = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // A data item mid-word needs no new keystream word
    a_skip_combine: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && s_valid && mode == MODE_DATA && !sts.phase_zero)
        |=> state_reg == ST_EMIT)
        else $error("mid-word data item did not go straight to emit");

    a_fill_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL && sts.fill_done) |=> state_reg == ST_IDLE)
        else $error("ring fill did not finish");

    a_combine_emit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_COMBINE |=> state_reg == ST_EMIT)
        else $error("word update did not hand over to emit");

endmodule

>>> design/clfsc_dp.sv
module clfsc_dp #(
    parameter int LFSR_STEPS_PER_WORD = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  clfsc_pkg::cmd_t                cmd,
    output clfsc_pkg::status_t             sts,
    input  logic [clfsc_pkg::WORD_W-1:0]   seed,
    input  logic [7:0]                     data_in,
    input  logic                           last_in,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [7:0]                     data_out,
    output logic                           last_out
);

    import clfsc_pkg::*;

    localparam int STEP_W = (LFSR_STEPS_PER_WORD > 1) ? $clog2(LFSR_STEPS_PER_WORD) : 1;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(LFSR_STEPS_PER_WORD - 1);

    logic [NUM_GEN-1:0][WORD_W-1:0] lfsr_reg, lfsr_next_w;
    logic [NUM_GEN-1:0][WORD_W-1:0] lfsr_stepped;
    logic [STEP_W-1:0]              step_reg, step_next;
    logic [HEAD_W-1:0]              fill_idx_reg, fill_idx_next;
    logic [NUM_GEN-1:0][HEAD_W-1:0] head_reg, head_next;
    logic [NUM_GEN-1:0]             carry_reg, carry_next;
    logic [WORD_W-1:0]              key_word_reg, key_word_next;
    logic [1:0]                     phase_reg, phase_next;
    logic                           seeded_reg, seeded_next;
    logic [7:0]                     data_reg;
    logic                           last_reg;
    logic                           out_valid_reg, out_valid_next;
    logic [7:0]                     out_data_reg;
    logic                           out_last_reg;

    logic                           maj;
    logic [NUM_GEN-1:0]             adv;
    logic [NUM_GEN-1:0][HEAD_W-1:0] h_inc, addr_a, addr_b;
    logic [WORD_W-1:0]              rd_a [NUM_GEN];
    logic [WORD_W-1:0]              rd_b [NUM_GEN];
    logic [WORD_W-1:0]              op_a [NUM_GEN];
    logic [WORD_W-1:0]              op_b [NUM_GEN];
    logic [WORD_W:0]                sum  [NUM_GEN];
    logic [NUM_GEN-1:0]             we;
    logic [HEAD_W-1:0]              waddr [NUM_GEN];
    logic [WORD_W-1:0]              wdata [NUM_GEN];
    logic [WORD_W-1:0]              word;
    logic [WORD_W-1:0]              s_mix, s_pairs, s_nibs;
    logic                           step_end;

    // Generators whose carry matches the majority advance
    assign maj = (carry_reg[0] & carry_reg[1]) | (carry_reg[0] & carry_reg[2])
               | (carry_reg[1] & carry_reg[2]);

    assign step_end = (step_reg == STEP_LAST);

    always_comb
    begin
        word = '0;
        for (int g = 0; g < NUM_GEN; g++)
        begin
            adv[g]          = (carry_reg[g] == maj);
            h_inc[g]        = head_reg[g] + 1'b1;
            addr_a[g]       = adv[g] ? (h_inc[g] - LAG_A[g]) : head_reg[g];
            addr_b[g]       = h_inc[g] - LAG_B[g];
            // Rings read as zero until the first reseed
            op_a[g]         = seeded_reg ? rd_a[g] : '0;
            op_b[g]         = seeded_reg ? rd_b[g] : '0;
            sum[g]          = {1'b0, op_a[g]} + {1'b0, op_b[g]};
            word            = word ^ (adv[g] ? sum[g][WORD_W-1:0] : op_a[g]);
            lfsr_stepped[g] = lfsr_next(lfsr_reg[g]);
            we[g]           = (cmd.fill_step && step_end) || (cmd.combine && adv[g]);
            waddr[g]        = cmd.fill_step ? fill_idx_reg : h_inc[g];
            wdata[g]        = cmd.fill_step ? lfsr_stepped[g] : sum[g][WORD_W-1:0];
        end
    end

    generate
        for (genvar g = 0; g < NUM_GEN; g++)
        begin : g_ring
            clfsc_ram #(
                .WIDTH (WORD_W),
                .DEPTH (RING_DEPTH)
            ) u_ring (
                .clk     (clk),
                .we      (we[g]),
                .waddr   (waddr[g]),
                .wdata   (wdata[g]),
                .raddr_a (addr_a[g]),
                .rdata_a (rd_a[g]),
                .raddr_b (addr_b[g]),
                .rdata_b (rd_b[g])
            );
        end
    endgenerate

    assign s_mix   = seed ^ SEED_MASK;
    assign s_pairs = ((s_mix >> 1) & PAIR_LO) | ((s_mix << 1) & PAIR_HI);
    assign s_nibs  = ~(((s_mix >> 4) & NIB_LO) | ((s_mix << 4) & NIB_HI));

    always_comb
    begin
        lfsr_next_w    = lfsr_reg;
        step_next      = step_reg;
        fill_idx_next  = fill_idx_reg;
        head_next      = head_reg;
        carry_next     = carry_reg;
        key_word_next  = key_word_reg;
        phase_next     = phase_reg;
        seeded_next    = seeded_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        priority if (cmd.start_fill)
        begin
            lfsr_next_w[0] = lfsr_next(s_mix);
            lfsr_next_w[1] = lfsr_next(s_pairs);
            lfsr_next_w[2] = lfsr_next(s_nibs);
            step_next      = '0;
            fill_idx_next  = '0;
            head_next      = {NUM_GEN{HEAD_RESET}};
            carry_next     = '0;
            key_word_next  = '0;
            phase_next     = '0;
            seeded_next    = 1'b1;
        end
        else if (cmd.fill_step)
        begin
            lfsr_next_w = lfsr_stepped;
            if (step_end)
            begin
                step_next     = '0;
                fill_idx_next = fill_idx_reg + 1'b1;
            end
            else
            begin
                step_next = step_reg + 1'b1;
            end
        end
        else if (cmd.combine)
        begin
            for (int g = 0; g < NUM_GEN; g++)
            begin
                if (adv[g])
                begin
                    head_next[g]  = h_inc[g];
                    carry_next[g] = sum[g][WORD_W];
                end
            end
            key_word_next = word;
        end
        else if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            phase_next     = phase_reg + 1'b1;
        end
        else
        begin
            seeded_next = seeded_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            fill_idx_reg  <= '0;
            head_reg      <= {NUM_GEN{HEAD_RESET}};
            carry_reg     <= '0;
            key_word_reg  <= '0;
            phase_reg     <= '0;
            seeded_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            fill_idx_reg  <= fill_idx_next;
            head_reg      <= head_next;
            carry_reg     <= carry_next;
            key_word_reg  <= key_word_next;
            phase_reg     <= phase_next;
            seeded_reg    <= seeded_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lfsr_reg <= lfsr_next_w;
        if (cmd.load)
        begin
            data_reg <= data_in;
            last_reg <= last_in;
        end
        if (cmd.emit)
        begin
            out_data_reg <= data_reg ^ key_word_reg[{phase_reg, 3'b000} +: 8];
            out_last_reg <= last_reg;
        end
    end

    assign sts.phase_zero = (phase_reg == 2'd0);
    assign sts.fill_done  = step_end && (fill_idx_reg == HEAD_RESET);
    assign sts.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign data_out  = out_data_reg;
    assign last_out  = out_last_reg;

    a_reseed_state: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start_fill |=> (head_reg == {NUM_GEN{HEAD_RESET}} && carry_reg == '0
                            && phase_reg == 2'd0 && seeded_reg))
        else $error("reseed did not restore heads, carries and phase");

    a_majority: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.combine |-> $countones(adv) >= 2)
        else $error("fewer than two generators advanced");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.out_free)
        else $error("result loaded over an item not yet taken");

endmodule

>>> dv/tb_clocked_lagged_fib_stream_cipher_top.sv
module tb_clocked_lagged_fib_stream_cipher_top;

    import clfsc_pkg::*;

    localparam int          STEPS_PER_WORD = 32;
    localparam int          KS_DEPTH       = 64;
    // Long enough for a reseed's whole ring fill, with margin
    localparam int          TAIL_CYCLES    = KS_DEPTH * STEPS_PER_WORD + 64;
    localparam int          CYCLE_LIMIT    = 400000;
    localparam int          RANDOM_ITEMS   = 400;
    localparam logic [31:0] KS_SEED_MASK   = 32'h0502_7919;

    // One item on the slave side, plus a flag that holds it back until all
    // predicted bytes have left the block
    typedef struct {
        logic        mode;
        logic [31:0] seed;
        logic [7:0]  data;
        logic        last;
        bit          drain_first;
    } cipher_item_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } cipher_byte_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;    // [31:0] seed, [39:32] data_in
    logic        s_tuser  = 1'b0;  // [0] mode
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;          // [7:0] data_out
    logic        m_tlast;

    // Keystream generator mirror: three rings, heads, carries, current word
    logic [31:0] ks_ring [0:2][0:KS_DEPTH-1];
    logic [5:0]  ks_head [0:2];
    logic [2:0]  ks_carry;
    logic [31:0] ks_word;
    logic [1:0]  ks_phase;

    cipher_item_t pending_items[$];
    cipher_byte_t cipher_bytes_due[$];

    bit          in_taken    = 1'b0;
    int unsigned fail_count  = 0;
    int unsigned cycle_count = 0;
    int unsigned burst_left  = 0;
    int unsigned gap_left    = 0;
    int unsigned stall_left  = 0;
    int unsigned rx_mode     = 0;

    clocked_lagged_fib_stream_cipher_top #(
        .LFSR_STEPS_PER_WORD (STEPS_PER_WORD)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #2 clk = ~clk;

    // Shift right once; bits 31, 6, 4, 2, 1 and 0 feed the new top bit
    function automatic logic [31:0] lfsr_step(input logic [31:0] v);
        logic fb;
        fb = v[31] ^ v[6] ^ v[4] ^ v[2] ^ v[1] ^ v[0];
        return {fb, v[31:1]};
    endfunction

    // Expand a seed into the three rings and restart the keystream position
    task automatic fill_rings(input logic [31:0] seed);
        logic [31:0] s;
        logic [31:0] v;
        logic [31:0] starts [0:2];
        s = seed ^ KS_SEED_MASK;
        starts[0] = s;
        starts[1] = ((s >> 1) & 32'h5555_5555) | ((s << 1) & 32'hAAAA_AAAA);
        starts[2] = ~(((s >> 4) & 32'h0F0F_0F0F) | ((s << 4) & 32'hF0F0_F0F0));
        for (int g = 0; g < 3; g++)
        begin
            v = lfsr_step(starts[g]);
            for (int k = 0; k < KS_DEPTH; k++)
            begin
                for (int n = 0; n < STEPS_PER_WORD; n++)
                    v = lfsr_step(v);
                ks_ring[g][k] = v;
            end
            ks_head[g] = 6'd63;
        end
        ks_carry = '0;
        ks_word  = '0;
        ks_phase = '0;
    endtask

    // Step one generator: new head word is the sum of two lagged words;
    // hand back the carry out of that sum
    function automatic logic ring_advance(input int g, input logic [5:0] lag_a,
                                          input logic [5:0] lag_b);
        logic [5:0]  h;
        logic [5:0]  ia;
        logic [5:0]  ib;
        logic [32:0] sum;
        h   = ks_head[g] + 6'd1;
        ia  = h - lag_a;
        ib  = h - lag_b;
        sum = {1'b0, ks_ring[g][ia]} + {1'b0, ks_ring[g][ib]};
        ks_ring[g][h] = sum[31:0];
        ks_head[g]    = h;
        return sum[32];
    endfunction

    // Advance every generator whose carry agrees with the majority, then
    // combine the three head words
    function automatic logic [31:0] next_key_word();
        logic maj;
        maj = (ks_carry[0] & ks_carry[1]) | (ks_carry[0] & ks_carry[2])
            | (ks_carry[1] & ks_carry[2]);
        if (ks_carry[0] == maj)
            ks_carry[0] = ring_advance(0, 6'd55, 6'd24);
        if (ks_carry[1] == maj)
            ks_carry[1] = ring_advance(1, 6'd57, 6'd7);
        if (ks_carry[2] == maj)
            ks_carry[2] = ring_advance(2, 6'd58, 6'd19);
        return ks_ring[0][ks_head[0]] ^ ks_ring[1][ks_head[1]] ^ ks_ring[2][ks_head[2]];
    endfunction

    // Work out what one accepted item should produce
    task automatic predict_cipher(input logic mode, input logic [31:0] seed,
                                  input logic [7:0] data, input logic last);
        logic [7:0]   ks;
        cipher_byte_t b;
        if (mode == MODE_RESEED)
            fill_rings(seed);
        else
        begin
            if (ks_phase == 2'd0)
                ks_word = next_key_word();
            ks       = 8'(ks_word >> (8 * ks_phase));
            ks_phase = ks_phase + 2'd1;
            b.data   = data ^ ks;
            b.last   = last;
            cipher_bytes_due.push_back(b);
        end
    endtask

    task automatic add_item(input logic mode, input logic [31:0] seed, input logic [7:0] data,
                            input logic last, input bit drain_first);
        cipher_item_t it;
        it.mode        = mode;
        it.seed        = seed;
        it.data        = data;
        it.last        = last;
        it.drain_first = drain_first;
        pending_items.push_back(it);
    endtask

    // Monitor: sample both handshakes at the rising edge. Predict first, so
    // that a byte's expectation is always queued before its result can be checked.
    always @(posedge clk)
    begin
        cipher_byte_t want;
        in_taken = 1'b0;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                in_taken = 1'b1;
                predict_cipher(s_tuser, s_tdata[31:0], s_tdata[39:32], s_tlast);
            end
            if (m_tvalid && m_tready)
            begin
                if (cipher_bytes_due.size() == 0)
                begin
                    $error("unexpected result: data_out %h, last_out %b", m_tdata, m_tlast);
                    fail_count++;
                end
                else
                begin
                    want = cipher_bytes_due.pop_front();
                    if (m_tdata !== want.data)
                    begin
                        $error("data_out mismatch: expected %h, actual %h", want.data, m_tdata);
                        fail_count++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last_out mismatch: expected %b, actual %b", want.last, m_tlast);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Driver: change the slave side on the falling edge. Hold an item until it
    // is taken, then either open a gap or present the next one. An item marked
    // drain_first waits until every predicted byte has left the block.
    always @(negedge clk)
    begin
        cipher_item_t it;
        if (rst_n && (!s_tvalid || in_taken))
        begin
            if (gap_left != 0)
            begin
                s_tvalid <= 1'b0;
                gap_left--;
            end
            else if (pending_items.size() != 0 &&
                     !(pending_items[0].drain_first && cipher_bytes_due.size() != 0))
            begin
                it = pending_items.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= it.mode;
                s_tdata  <= {it.data, it.seed};
                s_tlast  <= it.last;
                if (burst_left <= 1)
                begin
                    // New burst; now and then a long one with no gap at all
                    burst_left = $urandom_range(1, 40);
                    case ($urandom_range(0, 3))
                        0, 1:    gap_left = 0;
                        2:       gap_left = $urandom_range(1, 3);
                        default: gap_left = $urandom_range(4, 12);
                    endcase
                end
                else
                    burst_left--;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver: stall in windows of random length, each with its own
    // flavour - always ready, coin toss, or mostly stalled
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            rx_mode    = $urandom_range(0, 2);
            stall_left = $urandom_range(32, 200);
        end
        else
            stall_left--;
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Watchdog: end the run if it hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        int unsigned n_random;
        int unsigned seg;
        int unsigned len;

        // Mirror of the state after reset: zero rings, heads at the top
        for (int g = 0; g < 3; g++)
        begin
            for (int k = 0; k < KS_DEPTH; k++)
                ks_ring[g][k] = '0;
            ks_head[g] = 6'd63;
        end
        ks_carry = '0;
        ks_word  = '0;
        ks_phase = '0;

        // Data before any reseed passes through unchanged
        add_item(MODE_DATA, 32'h0000_0000, 8'h00, 1'b0, 1'b0);
        add_item(MODE_DATA, 32'hFFFF_FFFF, 8'hFF, 1'b1, 1'b0);
        add_item(MODE_DATA, 32'hFFFF_FFFF, 8'hA5, 1'b0, 1'b0);
        // Reseed with all-zero seed; data_in and last_in must be ignored
        add_item(MODE_RESEED, 32'h0000_0000, 8'hFF, 1'b1, 1'b0);
        // Nine bytes cross two word boundaries; a buffer ends on the first word's last byte
        for (int i = 0; i < 9; i++)
            add_item(MODE_DATA, $urandom, (i % 2) ? 8'hFF : 8'h00, (i == 3), 1'b0);
        // All-ones seed, presented only once the block has gone quiet
        add_item(MODE_RESEED, 32'hFFFF_FFFF, 8'h00, 1'b0, 1'b1);
        add_item(MODE_DATA, 32'hFFFF_FFFF, 8'h80, 1'b0, 1'b0);
        add_item(MODE_DATA, 32'h0000_0000, 8'h01, 1'b1, 1'b0);
        add_item(MODE_DATA, 32'hFFFF_FFFF, 8'hFF, 1'b0, 1'b0);
        add_item(MODE_DATA, 32'h0000_0000, 8'h7F, 1'b1, 1'b0);
        add_item(MODE_DATA, $urandom, 8'h00, 1'b0, 1'b0);
        // Seed equal to the mask: the first two generators start from zero
        add_item(MODE_RESEED, KS_SEED_MASK, 8'h5A, 1'b0, 1'b0);
        for (int i = 0; i < 4; i++)
            add_item(MODE_DATA, $urandom, 8'(i * 8'h3C), (i == 3), 1'b0);

        // Random part: reseed, then a run of data bytes. One long run takes
        // the rings past their wrap point; the rest are short, some empty.
        n_random = 0;
        seg      = 0;
        while (n_random < RANDOM_ITEMS)
        begin
            add_item(MODE_RESEED, $urandom, 8'($urandom), 1'($urandom), (seg % 3) == 1);
            n_random++;
            len = (seg == 1) ? 340 : $urandom_range(0, 30);
            for (int i = 0; i < len; i++)
                add_item(MODE_DATA, $urandom, 8'($urandom), ($urandom_range(0, 7) == 0), 1'b0);
            n_random += len;
            seg++;
        end

        // Hold reset, then release it on a falling edge
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait for the last item to go in, for every byte to come out, then
        // for a reseed's worth of cycles to catch any stray result
        while (pending_items.size() != 0 || s_tvalid)
            @(posedge clk);
        while (cipher_bytes_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0 && cipher_bytes_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
